/* hw/rtl/tjd_pkg.sv */
// Shared constants for the touch joystick dead-zone core.
`timescale 1ns / 1ps
`default_nettype none
package tjd_pkg;

  localparam int POINTER_COUNT_DEF = 16;

  // event kinds
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_DEAD_ZONE  = 3'd0;
  localparam logic [2:0] REG_STICK_SIZE = 3'd1;
  localparam logic [2:0] REG_FLOATING   = 3'd2;
  localparam logic [2:0] REG_AUTO_CTR   = 3'd3;
  localparam logic [2:0] REG_WCX        = 3'd4;
  localparam logic [2:0] REG_WCY        = 3'd5;

  // register reset values
  localparam logic [14:0] DEAD_ZONE_RST  = 15'd3277;
  localparam logic [15:0] STICK_SIZE_RST = 16'd200;
  localparam logic [14:0] WCX_RST        = 15'd100;
  localparam logic [14:0] WCY_RST        = 15'd100;

  // squared magnitude below which an idle stick counts as zero (1e-4 in Q30)
  localparam logic [32:0] SMALL_Q30 = 33'd107374;
  localparam logic [14:0] Q15_MAX   = 15'd32767;

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DEC  = 5'd1;
  localparam logic [4:0] S_P0   = 5'd2;
  localparam logic [4:0] S_P1   = 5'd3;
  localparam logic [4:0] S_P2   = 5'd4;
  localparam logic [4:0] S_P3   = 5'd5;
  localparam logic [4:0] S_P4   = 5'd6;
  localparam logic [4:0] S_SQ   = 5'd7;
  localparam logic [4:0] S_DVLD = 5'd8;
  localparam logic [4:0] S_DV   = 5'd9;
  localparam logic [4:0] S_T0   = 5'd10;
  localparam logic [4:0] S_T1   = 5'd11;
  localparam logic [4:0] S_T2   = 5'd12;
  localparam logic [4:0] S_T3   = 5'd13;
  localparam logic [4:0] S_D1   = 5'd14;
  localparam logic [4:0] S_D2   = 5'd15;
  localparam logic [4:0] S_D3   = 5'd16;
  localparam logic [4:0] S_D4   = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

endpackage
`default_nettype wire

/* hw/rtl/touch_joystick_deadzone_core.sv */
// Touch joystick core: pointer capture, radial clamp and dead-zone remap.
`timescale 1ns / 1ps
`default_nettype none
// Channel | dir | accepted when          | payload
// in_     | in  | in_tvalid & in_tready  | tuser: operation; tdata: pointer, x, y
// out_    | out | out_tvalid & out_tready| tuser: flags; tdata: stick x/y, drive x/y
// cfg_    | in  | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// An end or a rejected event goes straight to the output; a tick that does
// not inject only checks the value's magnitude; a start/move inside the radius
// runs two 16-step divisions, one outside it first 32 square-root steps on the
// shared compare-subtract unit; an injecting tick runs the square root, the
// dead-zone remap and two divisions, or skips the last two inside the dead zone.
// in_tready is high only while the sequencer idles; a result waiting on the
// output register lets the next beat in, which then holds until it drains.
// Reset (rst_n low, synchronous) restores register defaults and clears state.
// cfg_ready is always high; write only while idle.
module touch_joystick_deadzone_core #(
  parameter int POINTER_COUNT = tjd_pkg::POINTER_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  input  wire logic [39:0] in_tdata,   // [3:0] pointer_index, [19:4] touch_x, [35:20] touch_y
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [3:0]       out_tuser,  // [0] accepted, [1] activated, [2] deactivated, [3] inject
  output logic [63:0]      out_tdata,  // [15:0] stick_x, [31:16] stick_y,
                                       // [47:32] drive_x, [63:48] drive_y
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import tjd_pkg::*;

  localparam int PW    = $clog2(POINTER_COUNT + 1);
  localparam int CAP_W = (PW > 4) ? PW : 4;
  localparam logic [CAP_W-1:0] NONE = CAP_W'(POINTER_COUNT);

  // configuration
  logic [14:0] dz_r;
  logic [15:0] ss_cfg_r;
  logic        float_r, auto_r;
  logic [14:0] wcx_r, wcy_r;

  // architectural state
  logic             active_r, active_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [15:0]      cx_r, cx_nxt, cy_r, cy_nxt;
  logic [15:0]      vx_r, vx_nxt, vy_r, vy_nxt;

  // sequencer and datapath
  logic [4:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [3:0]  ptr_r, ptr_nxt;
  logic [15:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic        mode_drv_r, mode_drv_nxt;   // 1: divisions produce drive values
  logic        sel_y_r, sel_y_nxt;
  logic [15:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic        sx_r, sx_nxt, sy_r, sy_nxt;
  logic [47:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] m_r, m_nxt, t_r, t_nxt;
  logic [63:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [63:0] numx_r, numx_nxt, numy_r, numy_nxt, den_r, den_nxt;
  logic        acc_r, acc_nxt, act_r, act_nxt, deact_r, deact_nxt, inj_r, inj_nxt;
  logic [15:0] drx_r, drx_nxt, dry_r, dry_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [3:0]  ou_r, ou_nxt;
  logic [63:0] od_r, od_nxt;

  // shared compare-subtract unit
  logic [63:0] cu_b, cu_diff;
  logic        cu_ge;

  // misc combinational
  logic [3:0]       in_ptr;
  logic [CAP_W-1:0] ptr_ext;
  logic             ptr_ok;
  logic [15:0]      s_eff;
  logic [16:0]      dx, dy;
  logic [32:0]      qsum;
  logic [15:0]      qbits;
  logic [14:0]      qmag;
  logic [15:0]      qsigned;
  logic             qneg;
  logic [29:0]      dzs;

  assign in_ptr    = in_tdata[3:0];
  assign ptr_ext   = CAP_W'(ptr_r);
  assign ptr_ok    = ptr_ext < NONE;
  assign s_eff     = (ss_cfg_r < 16'd2) ? 16'd2 : ss_cfg_r;
  assign dx        = {tx_r[15], tx_r} - {cx_r[15], cx_r};
  assign dy        = {ty_r[15], ty_r} - {cy_r[15], cy_r};
  assign qsum      = {1'b0, pa_r[31:0]} + {1'b0, pb_r[31:0]};
  assign dzs       = {dz_r, 15'd0};
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tuser  = ou_r;
  assign out_tdata  = od_r;

  // root step compares against res+bit, divide step against the shifted divisor
  assign cu_b    = (state_r == S_SQ) ? (res_r + bit_r) : bit_r;
  assign cu_ge   = n_r >= cu_b;
  assign cu_diff = n_r - cu_b;

  // quotient of the last divide step, saturated and signed
  assign qbits   = {res_r[14:0], cu_ge};
  assign qmag    = qbits[15] ? Q15_MAX : qbits[14:0];
  assign qneg    = sel_y_r ? sy_r : sx_r;
  assign qsigned = qneg ? (16'd0 - {1'b0, qmag}) : {1'b0, qmag};

  always_comb begin
    state_nxt = state_r;  cnt_nxt = cnt_r;
    op_nxt = op_r;  ptr_nxt = ptr_r;  tx_nxt = tx_r;  ty_nxt = ty_r;
    active_nxt = active_r;  cap_nxt = cap_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  vx_nxt = vx_r;  vy_nxt = vy_r;
    mode_drv_nxt = mode_drv_r;  sel_y_nxt = sel_y_r;
    ax_nxt = ax_r;  ay_nxt = ay_r;  sx_nxt = sx_r;  sy_nxt = sy_r;
    pa_nxt = pa_r;  pb_nxt = pb_r;  pc_nxt = pc_r;  m_nxt = m_r;  t_nxt = t_r;
    n_nxt = n_r;  res_nxt = res_r;  bit_nxt = bit_r;
    numx_nxt = numx_r;  numy_nxt = numy_r;  den_nxt = den_r;
    acc_nxt = acc_r;  act_nxt = act_r;  deact_nxt = deact_r;  inj_nxt = inj_r;
    drx_nxt = drx_r;  dry_nxt = dry_r;
    ov_nxt = ov_r;  ou_nxt = ou_r;  od_nxt = od_r;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          ptr_nxt   = in_ptr;
          tx_nxt    = in_tdata[19:4];
          ty_nxt    = in_tdata[35:20];
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        acc_nxt = 1'b0;  act_nxt = 1'b0;  deact_nxt = 1'b0;  inj_nxt = 1'b0;
        drx_nxt = 16'd0;  dry_nxt = 16'd0;
        mode_drv_nxt = 1'b0;
        state_nxt = S_DONE;
        case (op_r)
          OP_START: begin
            if (ptr_ok && cap_r == NONE) begin
              cap_nxt    = ptr_ext;
              active_nxt = 1'b1;
              cx_nxt     = float_r ? tx_r : {1'b0, wcx_r};
              cy_nxt     = float_r ? ty_r : {1'b0, wcy_r};
              acc_nxt    = 1'b1;
              act_nxt    = 1'b1;
              state_nxt  = S_P0;
            end
          end
          OP_MOVE: begin
            if (ptr_ok && ptr_ext == cap_r) begin
              acc_nxt   = 1'b1;
              state_nxt = S_P0;
            end
          end
          OP_END: begin
            if (ptr_ok && ptr_ext == cap_r) begin
              if (auto_r) begin
                vx_nxt = 16'd0;
                vy_nxt = 16'd0;
              end
              active_nxt = 1'b0;
              cap_nxt    = NONE;
              acc_nxt    = 1'b1;
              deact_nxt  = 1'b1;
            end
          end
          default: state_nxt = S_T0;
        endcase
      end
      // offset magnitude and sign
      S_P0: begin
        sx_nxt = dx[16];
        sy_nxt = dy[16];
        ax_nxt = dx[16] ? 16'(17'd0 - dx) : dx[15:0];
        ay_nxt = dy[16] ? 16'(17'd0 - dy) : dy[15:0];
        state_nxt = S_P1;
      end
      S_P1: begin
        pa_nxt = 48'(ax_r * ax_r);
        state_nxt = S_P2;
      end
      S_P2: begin
        pb_nxt = 48'(ay_r * ay_r);
        state_nxt = S_P3;
      end
      S_P3: begin
        pc_nxt = s_eff * s_eff;
        state_nxt = S_P4;
      end
      // outside the radius normalize by the root, else scale by the stick size
      S_P4: begin
        if ({qsum, 2'b00} > {3'd0, pc_r}) begin
          n_nxt     = {1'b0, qsum, 30'd0};
          res_nxt   = 64'd0;
          bit_nxt   = 64'd1 << 62;
          cnt_nxt   = 5'd0;
          state_nxt = S_SQ;
        end else begin
          numx_nxt  = {32'd0, ax_r, 16'd0};
          numy_nxt  = {32'd0, ay_r, 16'd0};
          den_nxt   = {48'd0, s_eff};
          sel_y_nxt = 1'b0;
          state_nxt = S_DVLD;
        end
      end
      S_SQ: begin
        if (cu_ge) begin
          n_nxt   = cu_diff;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          if (mode_drv_r) begin
            m_nxt     = res_nxt[31:0];
            state_nxt = S_D1;
          end else begin
            den_nxt   = res_nxt;
            numx_nxt  = {18'd0, ax_r, 30'd0};
            numy_nxt  = {18'd0, ay_r, 30'd0};
            sel_y_nxt = 1'b0;
            state_nxt = S_DVLD;
          end
        end
      end
      // load remainder with the rounding half and the divisor shifted by 15
      S_DVLD: begin
        n_nxt     = (sel_y_r ? numy_r : numx_r) + (den_r >> 1);
        bit_nxt   = den_r << 15;
        res_nxt   = 64'd0;
        cnt_nxt   = 5'd0;
        state_nxt = S_DV;
      end
      S_DV: begin
        if (cu_ge) n_nxt = cu_diff;
        res_nxt = {res_r[62:0], cu_ge};
        bit_nxt = bit_r >> 1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          if (mode_drv_r) begin
            if (sel_y_r) dry_nxt = qsigned;
            else         drx_nxt = qsigned;
          end else begin
            if (sel_y_r) vy_nxt = qsigned;
            else         vx_nxt = qsigned;
          end
          if (sel_y_r) begin
            state_nxt = S_DONE;
          end else begin
            sel_y_nxt = 1'b1;
            state_nxt = S_DVLD;
          end
        end
      end
      S_T0: begin
        sx_nxt = vx_r[15];
        sy_nxt = vy_r[15];
        ax_nxt = vx_r[15] ? (16'd0 - vx_r) : vx_r;
        ay_nxt = vy_r[15] ? (16'd0 - vy_r) : vy_r;
        state_nxt = S_T1;
      end
      S_T1: begin
        pa_nxt = 48'(ax_r * ax_r);
        state_nxt = S_T2;
      end
      S_T2: begin
        pb_nxt = 48'(ay_r * ay_r);
        state_nxt = S_T3;
      end
      S_T3: begin
        if (active_r || qsum > SMALL_Q30) begin
          acc_nxt      = 1'b1;
          inj_nxt      = 1'b1;
          mode_drv_nxt = 1'b1;
          n_nxt        = {1'b0, qsum, 30'd0};
          res_nxt      = 64'd0;
          bit_nxt      = 64'd1 << 62;
          cnt_nxt      = 5'd0;
          state_nxt    = S_SQ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // inside the dead zone the drive stays zero
      S_D1: begin
        if (m_r == 32'd0 || m_r < {2'b00, dzs}) begin
          state_nxt = S_DONE;
        end else begin
          t_nxt     = m_r - {2'b00, dzs};
          state_nxt = S_D2;
        end
      end
      S_D2: begin
        pa_nxt = 48'(ax_r * t_r);
        state_nxt = S_D3;
      end
      S_D3: begin
        pb_nxt = 48'(ay_r * t_r);
        state_nxt = S_D4;
      end
      S_D4: begin
        den_nxt   = {16'd0, 48'(m_r * (16'd32768 - {1'b0, dz_r}))};
        numx_nxt  = {1'b0, pa_r, 15'd0};
        numy_nxt  = {1'b0, pb_r, 15'd0};
        sel_y_nxt = 1'b0;
        state_nxt = S_DVLD;
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          ou_nxt    = {inj_r, deact_r, act_r, acc_r};
          od_nxt    = {dry_r, drx_r, vy_r, vx_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
      cap_r    <= NONE;
      cx_r     <= 16'd0;
      cy_r     <= 16'd0;
      vx_r     <= 16'd0;
      vy_r     <= 16'd0;
      ov_r     <= 1'b0;
      dz_r     <= DEAD_ZONE_RST;
      ss_cfg_r <= STICK_SIZE_RST;
      float_r  <= 1'b0;
      auto_r   <= 1'b1;
      wcx_r    <= WCX_RST;
      wcy_r    <= WCY_RST;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      cap_r    <= cap_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      vx_r     <= vx_nxt;
      vy_r     <= vy_nxt;
      ov_r     <= ov_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_DEAD_ZONE:  dz_r     <= cfg_data[14:0];
          REG_STICK_SIZE: ss_cfg_r <= cfg_data;
          REG_FLOATING:   float_r  <= cfg_data[0];
          REG_AUTO_CTR:   auto_r   <= cfg_data[0];
          REG_WCX:        wcx_r    <= cfg_data[14:0];
          REG_WCY:        wcy_r    <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;  op_r <= op_nxt;  ptr_r <= ptr_nxt;
    tx_r <= tx_nxt;  ty_r <= ty_nxt;
    mode_drv_r <= mode_drv_nxt;  sel_y_r <= sel_y_nxt;
    ax_r <= ax_nxt;  ay_r <= ay_nxt;  sx_r <= sx_nxt;  sy_r <= sy_nxt;
    pa_r <= pa_nxt;  pb_r <= pb_nxt;  pc_r <= pc_nxt;  m_r <= m_nxt;  t_r <= t_nxt;
    n_r <= n_nxt;  res_r <= res_nxt;  bit_r <= bit_nxt;
    numx_r <= numx_nxt;  numy_r <= numy_nxt;  den_r <= den_nxt;
    acc_r <= acc_nxt;  act_r <= act_nxt;  deact_r <= deact_nxt;  inj_r <= inj_nxt;
    drx_r <= drx_nxt;  dry_r <= dry_nxt;
    ou_r <= ou_nxt;  od_r <= od_nxt;
  end

`ifndef SYNTHESIS
  a_cap_active: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r == NONE) == !active_r) else $error("capture and active disagree");
  a_value_sat: assert property (@(posedge clk) disable iff (!rst_n)
    vx_r != 16'h8000 && vy_r != 16'h8000) else $error("value out of Q1.15 range");
  a_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !ou_r[3] |-> od_r[63:32] == 32'd0) else $error("drive without inject");
  a_flags_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (ou_r[1] || ou_r[2] || ou_r[3]) |-> ou_r[0]) else $error("flag without accept");
`endif

endmodule
`default_nettype wire
